@@ rtl/stereo_sad_block_match_macros.svh @@
// ----------------------------------------------------------------------------
// stereo_sad_block_match_macros.svh
// Assertion shorthands shared by the checker of the stereo block matcher.
// ----------------------------------------------------------------------------
`ifndef STEREO_SAD_BLOCK_MATCH_MACROS_SVH
`define STEREO_SAD_BLOCK_MATCH_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SSBM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SSBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ssbm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssbm_pkg
// Types and constants of the SAD stereo block matcher.
// ----------------------------------------------------------------------------
package ssbm_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HALF_DEF   = 4;
   localparam int DISP_RANGE_DEF = 64;

   localparam int PIX_W    = 8;
   localparam int WIDTH_W  = 11;
   localparam int ROW_W    = 12;
   localparam int HALF_W   = 3;
   localparam int DISP_W   = 6;
   localparam int COST_W   = 15;
   localparam int COST_CAP = (1 << COST_W) - 1;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [WIDTH_W-1:0] WIDTH_RST  = 11'd640;
   localparam logic [ROW_W-1:0]   HEIGHT_RST = 12'd480;
   localparam logic [HALF_W-1:0]  HALF_RST   = 3'd2;
   localparam logic [DISP_W-1:0]  DMIN_RST   = 6'd0;
   localparam logic [DISP_W-1:0]  DMAX_RST   = 6'd63;

   // register index = byte address / 4
   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_WINDOW_HALF   = 3'd2;
   localparam logic [2:0] REG_MIN_DISPARITY = 3'd3;
   localparam logic [2:0] REG_MAX_DISPARITY = 3'd4;

   typedef struct packed {
      logic [PIX_W-1:0] left_pixel;
      logic [PIX_W-1:0] right_pixel;
      logic             start_of_frame;
   } ssbm_req_type;

   typedef struct packed {
      logic [DISP_W-1:0] disparity;
      logic [COST_W-1:0] best_cost;
      logic              end_of_row;
      logic              end_of_frame;
   } ssbm_rsp_type;

   typedef struct packed {
      logic clear;
      logic accum;
      logic shift;
   } ssbm_cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_SCAN,
      ST_FINISH
   } ssbm_state_type;

endpackage

@@ rtl/ssbm_line_store.sv @@
// ----------------------------------------------------------------------------
// ssbm_line_store
// Left and right row stores: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssbm_line_store #(
   parameter int DEPTH = (2 * ssbm_pkg::MAX_HALF_DEF + 1) << $clog2(ssbm_pkg::MAX_WIDTH_DEF)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [ssbm_pkg::PIX_W-1:0]   wr_left,
   input  logic [ssbm_pkg::PIX_W-1:0]   wr_right,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [ssbm_pkg::PIX_W-1:0]   rd_left,
   output logic [ssbm_pkg::PIX_W-1:0]   rd_right
);
   import ssbm_pkg::*;

   logic [PIX_W-1:0] left_mem  [DEPTH];
   logic [PIX_W-1:0] right_mem [DEPTH];
   logic [PIX_W-1:0] rd_left_ff;
   logic [PIX_W-1:0] rd_right_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr]  <= wr_left;
         right_mem[wr_addr] <= wr_right;
      end
      rd_left_ff  <= left_mem[rd_addr];
      rd_right_ff <= right_mem[rd_addr];
   end

   assign rd_left  = rd_left_ff;
   assign rd_right = rd_right_ff;

endmodule

@@ rtl/ssbm_cell.sv @@
// ----------------------------------------------------------------------------
// ssbm_cell
// One disparity cell: right pixel tap plus SAD accumulator, both chained.
// ----------------------------------------------------------------------------
module ssbm_cell #(
   parameter int SUM_W = 17
) (
   input  logic                           clock,
   input  ssbm_pkg::ssbm_cell_ctrl_type   ctrl,
   input  logic [ssbm_pkg::PIX_W-1:0]     left_pix,
   input  logic [ssbm_pkg::PIX_W-1:0]     prev_pix,
   input  logic [SUM_W-1:0]               prev_sum,
   output logic [ssbm_pkg::PIX_W-1:0]     pix_out,
   output logic [SUM_W-1:0]               sum_out
);
   import ssbm_pkg::*;

   logic [PIX_W-1:0] pix_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [PIX_W-1:0] diff;

   assign diff = (left_pix > pix_ff) ? left_pix - pix_ff : pix_ff - left_pix;

   always_comb begin
      priority if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.shift) begin
         sum_in = prev_sum;
      end else if (ctrl.accum) begin
         sum_in = sum_ff + SUM_W'(diff);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= prev_pix;
      sum_ff <= sum_in;
   end

   assign pix_out = pix_ff;
   assign sum_out = sum_ff;

endmodule

@@ rtl/stereo_sad_block_match.sv @@
// ----------------------------------------------------------------------------
// stereo_sad_block_match
// SAD stereo block matcher over a chain of per-disparity cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one left/right pixel pair per item in raster order;
//   start_of_frame puts the pair at row 0, column 0. rsp channel gives the
//   chosen disparity and its window cost for each valid centre, h rows and
//   h columns behind the input. csr is an APB port for width, height,
//   window half size and the disparity range; write it only while idle.
// Timing:
//   An item that yields no result is taken without a stall. An item that
//   yields one holds req_stall after it is taken while the search runs:
//   each window row is streamed from the single read port of the row
//   stores through the cell chain, the pipeline drains, then the costs
//   are shifted out of the chain one per cycle into the minimum search.
//   With rsp_stall low the result item shows on rsp_valid at the edge
//   where req_stall falls.
// Reset:
//   synchronous; position returns to row 0 column 0, registers to their
//   defaults, no result pending. Row stores are not cleared.
// Stall:
//   a finished result waits in the output register while rsp_stall is
//   high; the next item is taken meanwhile and its search stops at the
//   end until the output register frees up.
// ----------------------------------------------------------------------------
module stereo_sad_block_match #(
   parameter int MAX_WIDTH  = ssbm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HALF   = ssbm_pkg::MAX_HALF_DEF,
   parameter int DISP_RANGE = ssbm_pkg::DISP_RANGE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ssbm_pkg::ssbm_req_type            req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ssbm_pkg::ssbm_rsp_type            rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ssbm_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [ssbm_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [ssbm_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import ssbm_pkg::*;

   localparam int LINE_ROWS = 2 * MAX_HALF + 1;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int CW1   = CW + 1;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW1   = ROW_W + 1;
   localparam int SW    = $clog2(LINE_ROWS);
   localparam int HW    = $clog2(MAX_HALF + 1);
   localparam int DW    = $clog2(DISP_RANGE);
   localparam int TW    = $clog2(2 * MAX_HALF + DISP_RANGE);
   localparam int LW    = $clog2(2 * MAX_HALF + DISP_RANGE + MAX_WIDTH);
   localparam int SUM_W = $clog2(LINE_ROWS * LINE_ROWS * ((1 << PIX_W) - 1) + 1);
   localparam int AW    = SW + CW;
   localparam int DEPTH = LINE_ROWS << CW;

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      return (s == SW'(LINE_ROWS - 1)) ? '0 : s + 1'b1;
   endfunction

   // configuration
   logic [WIDTH_W-1:0] width_ff;
   logic [ROW_W-1:0]   height_ff;
   logic [HALF_W-1:0]  half_ff;
   logic [DISP_W-1:0]  dmin_ff;
   logic [DISP_W-1:0]  dmax_ff;
   logic               csr_wr;

   // effective settings
   logic [WW-1:0]    w_eff;
   logic [ROW_W-1:0] hgt_eff;
   logic [HW-1:0]    h_eff;
   logic [DW-1:0]    dmin_eff;
   logic [DW-1:0]    dmax_eff;
   logic [DW-1:0]    dmax_clip;
   logic [HW:0]      two_h;
   logic [LW-1:0]    span;

   // position
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [CW-1:0]    pos_col;
   logic [ROW_W-1:0] pos_row;
   logic [SW-1:0]    pos_slot;

   // sequencer
   ssbm_state_type  state_ff, state_in;
   logic            accept;
   logic            need_out;
   logic [CW-1:0]   acol_ff, acol_in;
   logic [SW-1:0]   rslot_ff, rslot_in;
   logic [SW-1:0]   start_slot;
   logic [HW:0]     rcnt_ff, rcnt_in;
   logic [TW-1:0]   t_ff, t_in;
   logic [DW-1:0]   k_ff, k_in;
   logic            w1_ff, w1_in;
   logic            w2_ff;
   logic            eor_ff, eor_in, eof_ff, eof_in;
   logic            pos_eor;
   logic [SUM_W-1:0] best_ff, best_in;
   logic [DW-1:0]   bd_ff, bd_in;
   logic            bvld_ff, bvld_in;
   logic            rsp_valid_ff, rsp_valid_in;
   ssbm_rsp_type    rsp_data_ff, rsp_data_in;
   logic [COST_W-1:0] cost_sat;

   // datapath
   logic [AW-1:0]    rd_addr;
   logic [PIX_W-1:0] rd_left, rd_right;
   logic [PIX_W-1:0] lft_ff;
   ssbm_cell_ctrl_type cell_ctrl;
   logic [PIX_W-1:0] pix_chain [DISP_RANGE];
   logic [SUM_W-1:0] sum_chain [DISP_RANGE];

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         half_ff   <= HALF_RST;
         dmin_ff   <= DMIN_RST;
         dmax_ff   <= DMAX_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[CSR_AW-1:2])
            REG_IMAGE_WIDTH:   width_ff  <= csr_pwdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:  height_ff <= csr_pwdata[ROW_W-1:0];
            REG_WINDOW_HALF:   half_ff   <= csr_pwdata[HALF_W-1:0];
            REG_MIN_DISPARITY: dmin_ff   <= csr_pwdata[DISP_W-1:0];
            REG_MAX_DISPARITY: dmax_ff   <= csr_pwdata[DISP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_AW-1:2])
         REG_IMAGE_WIDTH:   csr_prdata = CSR_DW'(width_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = CSR_DW'(height_ff);
         REG_WINDOW_HALF:   csr_prdata = CSR_DW'(half_ff);
         REG_MIN_DISPARITY: csr_prdata = CSR_DW'(dmin_ff);
         REG_MAX_DISPARITY: csr_prdata = CSR_DW'(dmax_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- effective settings ----------------
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      hgt_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;
      if (half_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(half_ff) > 32'(MAX_HALF)) begin
         h_eff = HW'(MAX_HALF);
      end else begin
         h_eff = HW'(half_ff);
      end
      dmin_eff  = (32'(dmin_ff) >= 32'(DISP_RANGE)) ? DW'(DISP_RANGE - 1) : DW'(dmin_ff);
      dmax_clip = (32'(dmax_ff) >= 32'(DISP_RANGE)) ? DW'(DISP_RANGE - 1) : DW'(dmax_ff);
      dmax_eff  = (dmax_clip < dmin_eff) ? dmin_eff : dmax_clip;
      two_h     = {h_eff, 1'b0};
      span      = LW'(two_h) + LW'(dmax_eff);
   end

   // ---------------- position of the incoming item ----------------
   always_comb begin : pos_calc
      logic [CW:0]    c0;
      logic [ROW_W:0] r0;
      logic [SW-1:0]  s0;
      logic [CW:0]    cn;
      logic [ROW_W:0] rn;
      logic [SW-1:0]  sn;
      c0 = req_payload.start_of_frame ? '0 : {1'b0, col_ff};
      r0 = req_payload.start_of_frame ? '0 : {1'b0, row_ff};
      s0 = req_payload.start_of_frame ? '0 : slot_ff;
      // a column left out of range by a narrower width wraps first
      if (c0 >= CW1'(w_eff)) begin
         c0 = '0;
         r0 = r0 + 1'b1;
         s0 = slot_inc(s0);
      end
      if (r0 >= RW1'(hgt_eff)) begin
         r0 = '0;
         s0 = '0;
      end
      pos_col  = CW'(c0);
      pos_row  = ROW_W'(r0);
      pos_slot = s0;
      cn = c0 + 1'b1;
      rn = r0;
      sn = s0;
      if (cn >= CW1'(w_eff)) begin
         cn = '0;
         rn = r0 + 1'b1;
         sn = slot_inc(s0);
         if (rn >= RW1'(hgt_eff)) begin
            rn = '0;
            sn = '0;
         end
      end
      col_in  = CW'(cn);
      row_in  = ROW_W'(rn);
      slot_in = sn;
   end

   assign need_out = (pos_row >= ROW_W'(two_h)) && (LW'(pos_col) >= span);
   assign pos_eor  = (pos_col == CW'(w_eff - 1'b1));
   assign start_slot = (pos_slot >= SW'(two_h)) ? pos_slot - SW'(two_h)
                                                : pos_slot + SW'(LINE_ROWS) - SW'(two_h);

   // ---------------- sequencer ----------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      acol_in      = acol_ff;
      rslot_in     = rslot_ff;
      rcnt_in      = rcnt_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      eor_in       = eor_ff;
      eof_in       = eof_ff;
      best_in      = best_ff;
      bd_in        = bd_ff;
      bvld_in      = bvld_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      w1_in        = 1'b0;
      cost_sat     = (32'(best_ff) > 32'(COST_CAP)) ? COST_W'(COST_CAP) : COST_W'(best_ff);
      rd_addr      = {rslot_ff, CW'(LW'(acol_ff) + LW'(t_ff))};
      cell_ctrl    = '{clear: accept, accum: w2_ff, shift: (state_ff == ST_SCAN)};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && need_out) begin
               state_in = ST_SWEEP;
               acol_in  = CW'(LW'(pos_col) - span);
               rslot_in = start_slot;
               rcnt_in  = '0;
               t_in     = '0;
               eor_in   = pos_eor;
               eof_in   = pos_eor && (pos_row == hgt_eff - 1'b1);
               bvld_in  = 1'b0;
            end
         end
         ST_SWEEP: begin
            // left columns start dmax steps into the right stream
            w1_in = (LW'(t_ff) >= LW'(dmax_eff));
            if (LW'(t_ff) == span) begin
               t_in = '0;
               if (rcnt_ff == two_h) begin
                  state_in = ST_DRAIN;
               end else begin
                  rcnt_in  = rcnt_ff + 1'b1;
                  rslot_in = slot_inc(rslot_ff);
               end
            end else begin
               t_in = t_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!w1_ff && !w2_ff) begin
               state_in = ST_SCAN;
               k_in     = DW'(DISP_RANGE - 1);
            end
         end
         ST_SCAN: begin
            // costs leave the chain end from the largest disparity down;
            // strict compare keeps the larger disparity on a tie
            if (k_ff >= dmin_eff && k_ff <= dmax_eff &&
                (!bvld_ff || sum_chain[DISP_RANGE-1] < best_ff)) begin
               best_in = sum_chain[DISP_RANGE-1];
               bd_in   = k_ff;
               bvld_in = 1'b1;
            end
            if (k_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{disparity:    DISP_W'(bd_ff),
                                best_cost:    cost_sat,
                                end_of_row:   eor_ff,
                                end_of_frame: eof_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         rcnt_ff      <= '0;
         t_ff         <= '0;
         k_ff         <= '0;
         w1_ff        <= 1'b0;
         w2_ff        <= 1'b0;
         bvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            slot_ff <= slot_in;
         end
         rcnt_ff      <= rcnt_in;
         t_ff         <= t_in;
         k_ff         <= k_in;
         w1_ff        <= w1_in;
         w2_ff        <= w1_ff;
         bvld_ff      <= bvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acol_ff     <= acol_in;
      rslot_ff    <= rslot_in;
      eor_ff      <= eor_in;
      eof_ff      <= eof_in;
      best_ff     <= best_in;
      bd_ff       <= bd_in;
      rsp_data_ff <= rsp_data_in;
      lft_ff      <= rd_left;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ---------------- row stores ----------------
   ssbm_line_store #(
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock    (clock),
      .wr_en    (accept),
      .wr_addr  ({pos_slot, pos_col}),
      .wr_left  (req_payload.left_pixel),
      .wr_right (req_payload.right_pixel),
      .rd_addr  (rd_addr),
      .rd_left  (rd_left),
      .rd_right (rd_right)
   );

   // ---------------- disparity cell chain ----------------
   for (genvar k = 0; k < DISP_RANGE; k++) begin : g_cell
      logic [PIX_W-1:0] prev_pix;
      logic [SUM_W-1:0] prev_sum;
      if (k == 0) begin : g_head
         assign prev_pix = rd_right;
         assign prev_sum = '0;
      end else begin : g_link
         assign prev_pix = pix_chain[k-1];
         assign prev_sum = sum_chain[k-1];
      end
      ssbm_cell #(
         .SUM_W (SUM_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .left_pix (lft_ff),
         .prev_pix (prev_pix),
         .prev_sum (prev_sum),
         .pix_out  (pix_chain[k]),
         .sum_out  (sum_chain[k])
      );
   end

endmodule

@@ rtl/ssbm_checker.sv @@
// ----------------------------------------------------------------------------
// ssbm_checker
// Port-level checks of the stereo block matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_sad_block_match_macros.svh"

module ssbm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ssbm_pkg::ssbm_rsp_type rsp_payload
);
   import ssbm_pkg::*;

   `SSBM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result item changed")
   `SSBM_ASSERT_IMPLY(a_eof_eor, rsp_valid && rsp_payload.end_of_frame, rsp_payload.end_of_row, "end of frame without end of row")
   `SSBM_ASSERT_IMPLY(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall), "result item without a search")
   `SSBM_ASSERT_IMPLY(a_reset_idle, $past(reset), !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind stereo_sad_block_match ssbm_checker u_ssbm_checker (.*);
